// File: rtl/txtint_pkg.sv
package txtint_pkg;

    localparam longint unsigned COUNT_LIMIT_DEFAULT = 64'd65535;

    localparam int CHAR_W   = 8;
    localparam int RADIX_W  = 6;
    localparam int VALUE_W  = 64;
    localparam int COUNT_W  = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_DATA_W = VALUE_W + COUNT_W;

    // Register indexes of the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX       = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED_MODE = 8'd1;

    // Character codes.
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_VT    = 8'h0B;
    localparam logic [CHAR_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
    localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;

    localparam logic [RADIX_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [RADIX_W-1:0] BASE_8    = 6'd8;
    localparam logic [RADIX_W-1:0] BASE_10   = 6'd10;
    localparam logic [RADIX_W-1:0] BASE_16   = 6'd16;
    localparam logic [RADIX_W-1:0] LETTER_OFFSET = 6'd10;

    typedef struct packed {
        logic               valid;
        logic [RADIX_W-1:0] value;
    } digit_t;

    function automatic logic is_blank(input logic [CHAR_W-1:0] c);
        is_blank = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
                   (c == CH_VT) || (c == CH_FF) || (c == CH_CR);
    endfunction

    function automatic digit_t decode_digit(input logic [CHAR_W-1:0] c);
        digit_t d;
        d.valid = 1'b1;
        d.value = '0;
        if (c inside {[CH_0:CH_9]})
            d.value = RADIX_W'(c - CH_0);
        else if (c inside {[CH_LA:CH_LZ]})
            d.value = RADIX_W'(c - CH_LA) + LETTER_OFFSET;
        else if (c inside {[CH_UA:CH_UZ]})
            d.value = RADIX_W'(c - CH_UA) + LETTER_OFFSET;
        else
            d.valid = 1'b0;
        decode_digit = d;
    endfunction

endpackage

// File: rtl/text_to_integer_radix_parser.sv
// A byte accepted on s_axis is held in the input register; its result, if it is the marked
// last byte, is registered once the result slot is free and then shows on m_axis.
// Throughput: one byte per cycle while no last byte waits on a held result slot; the per-byte
// step (decode plus a 64-by-6 multiply-add) sits between the input register and the state/result registers.
// Reset: rst_n clears the parse state, both valid flags, and sets radix 0, signed mode 1.
module text_to_integer_radix_parser #(
    parameter longint unsigned COUNT_LIMIT = txtint_pkg::COUNT_LIMIT_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // Configuration write channel.
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [txtint_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [txtint_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Input stream.
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [txtint_pkg::CHAR_W-1:0]      s_axis_tdata,   // [7:0] char_in
    input  logic                               s_axis_tlast,   // end_of_string
    // Result stream.
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [txtint_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // [63:0] value_bits,
                                                               // [79:64] consumed_count
);

    localparam int CNT_W = $clog2(COUNT_LIMIT + 64'd1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(COUNT_LIMIT);

    localparam logic [2:0] PH_SPACE  = 3'd0;
    localparam logic [2:0] PH_PREFIX = 3'd1;
    localparam logic [2:0] PH_ZERO   = 3'd2;
    localparam logic [2:0] PH_DIGITS = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    logic [txtint_pkg::RADIX_W-1:0] radix_reg;
    logic                           signed_mode_reg;

    logic                           in_valid_reg;
    logic [txtint_pkg::CHAR_W-1:0]  in_char_reg;
    logic                           in_last_reg;

    logic [2:0]                     phase_reg, phase_next;
    logic [txtint_pkg::VALUE_W-1:0] acc_reg, acc_next;
    logic                           neg_reg, neg_next;
    logic [txtint_pkg::RADIX_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;

    logic                           out_valid_reg;
    logic [txtint_pkg::VALUE_W-1:0] out_value_reg;
    logic [txtint_pkg::COUNT_W-1:0] out_count_reg;

    logic                           advance;
    logic                           used;
    logic                           bump;
    txtint_pkg::digit_t             dig;
    logic [txtint_pkg::VALUE_W-1:0] result_value;

    assign cfg_ready = 1'b1;

    // A byte leaves the input register unless it is a last byte and the result slot is held.
    assign advance = in_valid_reg &&
                     (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    assign dig = txtint_pkg::decode_digit(in_char_reg);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        base_next  = base_reg;
        used       = 1'b0;
        bump       = 1'b0;

        if (phase_next == PH_SPACE)
        begin
            if (txtint_pkg::is_blank(in_char_reg))
            begin
                bump = 1'b1;
                used = 1'b1;
            end
            else if (in_char_reg == txtint_pkg::CH_MINUS && signed_mode_reg)
            begin
                neg_next   = 1'b1;
                bump       = 1'b1;
                used       = 1'b1;
                phase_next = PH_PREFIX;
            end
            else if (in_char_reg == txtint_pkg::CH_PLUS)
            begin
                bump       = 1'b1;
                used       = 1'b1;
                phase_next = PH_PREFIX;
            end
            else
            begin
                phase_next = PH_PREFIX;
            end
        end

        if (!used && phase_next == PH_PREFIX)
        begin
            if ((radix_reg == txtint_pkg::BASE_AUTO || radix_reg == txtint_pkg::BASE_16) &&
                in_char_reg == txtint_pkg::CH_0)
            begin
                bump       = 1'b1;
                used       = 1'b1;
                base_next  = (radix_reg == txtint_pkg::BASE_AUTO) ? txtint_pkg::BASE_8
                                                                  : txtint_pkg::BASE_16;
                phase_next = PH_ZERO;
            end
            else
            begin
                base_next  = (radix_reg == txtint_pkg::BASE_AUTO) ? txtint_pkg::BASE_10
                                                                  : radix_reg;
                phase_next = PH_DIGITS;
            end
        end

        if (!used && phase_next == PH_ZERO)
        begin
            if (in_char_reg == txtint_pkg::CH_LX || in_char_reg == txtint_pkg::CH_UX)
            begin
                base_next = txtint_pkg::BASE_16;
                bump      = 1'b1;
                used      = 1'b1;
            end
            phase_next = PH_DIGITS;
        end

        if (!used && phase_next == PH_DIGITS)
        begin
            if (dig.valid && dig.value < base_next)
            begin
                acc_next = acc_reg * txtint_pkg::VALUE_W'(base_next)
                         + txtint_pkg::VALUE_W'(dig.value);
                bump     = 1'b1;
            end
            else
            begin
                phase_next = PH_DONE;
            end
        end

        cnt_next = cnt_reg;
        if (bump && cnt_reg != CNT_MAX)
            cnt_next = cnt_reg + CNT_W'(1);

        result_value = neg_next ? (txtint_pkg::VALUE_W'(0) - acc_next) : acc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg       <= txtint_pkg::BASE_AUTO;
            signed_mode_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                txtint_pkg::REG_RADIX:
                    radix_reg <= cfg_data[txtint_pkg::RADIX_W-1:0];
                txtint_pkg::REG_SIGNED_MODE:
                    signed_mode_reg <= cfg_data[0];
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SPACE;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            base_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                phase_reg <= PH_SPACE;
                acc_reg   <= '0;
                neg_reg   <= 1'b0;
                base_reg  <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                base_reg  <= base_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_last_reg)
        begin
            out_value_reg <= result_value;
            out_count_reg <= txtint_pkg::COUNT_W'(cnt_next);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_count_reg, out_value_reg};

endmodule

// File: rtl/txtint_checker.sv
module txtint_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               s_axis_tvalid,
    input logic                               s_axis_tready,
    input logic                               s_axis_tlast,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [txtint_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

    // A held result keeps its valid and its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // The result slot only empties through a completed transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without a transaction");

    // The input side stalls only behind a held result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled with the result slot free");

    // A fresh result follows the acceptance of its last byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a last byte");

endmodule

bind text_to_integer_radix_parser txtint_checker u_txtint_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: bench/text_to_integer_radix_parser_test.sv
`timescale 1ns / 100ps

module text_to_integer_radix_parser_test;

    localparam logic [txtint_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
    localparam int unsigned NO_DIGIT = 255;
    localparam int unsigned LONG_BLANK_RUN = 48;

    typedef enum logic [2:0] {
        SCAN_BLANKS,
        SCAN_PREFIX,
        SCAN_ZERO,
        SCAN_DIGITS,
        SCAN_STOPPED
    } scan_phase_t;

    typedef struct packed {
        logic [txtint_pkg::CHAR_W-1:0] ch;
        logic                          last;
    } text_byte_t;

    typedef struct packed {
        logic [txtint_pkg::VALUE_W-1:0] value;
        logic [txtint_pkg::COUNT_W-1:0] count;
    } parse_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                   cfg_valid = 1'b0;
    logic                                   cfg_ready;
    logic [txtint_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
    logic [txtint_pkg::CFG_DATA_W-1:0]      cfg_data = '0;

    logic                                   s_axis_tvalid = 1'b0;
    logic                                   s_axis_tready;
    logic [txtint_pkg::CHAR_W-1:0]          s_axis_tdata = '0;
    logic                                   s_axis_tlast = 1'b0;

    logic                                   m_axis_tvalid;
    logic                                   m_axis_tready = 1'b0;
    logic [txtint_pkg::OUT_DATA_W-1:0]      m_axis_tdata;

    text_to_integer_radix_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Stimulus and expectation stores.
    text_byte_t    text_q[$];
    parse_result_t pending_numbers[$];

    // Local copy of the parser state and registers.
    logic [txtint_pkg::RADIX_W-1:0] radix_reg;
    logic                           signed_reg;
    scan_phase_t                    scan_phase;
    logic [txtint_pkg::VALUE_W-1:0] acc_value;
    logic                           minus_seen;
    int unsigned                    digit_base;
    int unsigned                    taken_count;

    int unsigned errors = 0;
    int unsigned strings_done = 0;
    int unsigned bytes_queued = 0;
    int unsigned settings_used = 0;

    bit          in_taken = 1'b0;
    bit          calm_in = 1'b0;
    bit          calm_out = 1'b0;
    int unsigned send_gap = 0;
    int unsigned stall_left = 0;
    text_byte_t  next_byte;
    parse_result_t want;

    task automatic report_mismatch(input string what);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at %0t: %s", $time, what);
    endtask

    function automatic bit is_white(input logic [txtint_pkg::CHAR_W-1:0] c);
        return c inside {txtint_pkg::CH_SPACE, txtint_pkg::CH_TAB, txtint_pkg::CH_LF,
                         txtint_pkg::CH_VT, txtint_pkg::CH_FF, txtint_pkg::CH_CR};
    endfunction

    function automatic int unsigned char_digit(input logic [txtint_pkg::CHAR_W-1:0] c);
        if (c >= txtint_pkg::CH_0 && c <= txtint_pkg::CH_9)
            return c - txtint_pkg::CH_0;
        if (c >= txtint_pkg::CH_LA && c <= txtint_pkg::CH_LZ)
            return c - txtint_pkg::CH_LA + 10;
        if (c >= txtint_pkg::CH_UA && c <= txtint_pkg::CH_UZ)
            return c - txtint_pkg::CH_UA + 10;
        return NO_DIGIT;
    endfunction

    function automatic void bump_taken();
        if (taken_count < txtint_pkg::COUNT_LIMIT_DEFAULT)
            taken_count++;
    endfunction

    function automatic void clear_scan();
        scan_phase = SCAN_BLANKS;
        acc_value = '0;
        minus_seen = 1'b0;
        digit_base = 0;
        taken_count = 0;
    endfunction

    // Advances the parse by one accepted byte; a marked last byte yields a result.
    function automatic void scan_char(input logic [txtint_pkg::CHAR_W-1:0] c, input logic last);
        bit            used;
        int unsigned   d;
        parse_result_t res;
        used = 1'b0;
        if (scan_phase == SCAN_BLANKS)
        begin
            if (is_white(c))
            begin
                bump_taken();
                used = 1'b1;
            end
            else if (c == txtint_pkg::CH_MINUS && signed_reg)
            begin
                minus_seen = 1'b1;
                bump_taken();
                scan_phase = SCAN_PREFIX;
                used = 1'b1;
            end
            else if (c == txtint_pkg::CH_PLUS)
            begin
                bump_taken();
                scan_phase = SCAN_PREFIX;
                used = 1'b1;
            end
            else
                scan_phase = SCAN_PREFIX;
        end
        if (!used && scan_phase == SCAN_PREFIX)
        begin
            if ((radix_reg == txtint_pkg::BASE_AUTO || radix_reg == txtint_pkg::BASE_16) &&
                c == txtint_pkg::CH_0)
            begin
                bump_taken();
                digit_base = (radix_reg == txtint_pkg::BASE_AUTO) ? txtint_pkg::BASE_8
                                                                  : txtint_pkg::BASE_16;
                scan_phase = SCAN_ZERO;
                used = 1'b1;
            end
            else
            begin
                digit_base = (radix_reg == txtint_pkg::BASE_AUTO) ? txtint_pkg::BASE_10
                                                                  : radix_reg;
                scan_phase = SCAN_DIGITS;
            end
        end
        if (!used && scan_phase == SCAN_ZERO)
        begin
            if (c == txtint_pkg::CH_LX || c == txtint_pkg::CH_UX)
            begin
                digit_base = txtint_pkg::BASE_16;
                bump_taken();
                used = 1'b1;
            end
            scan_phase = SCAN_DIGITS;
        end
        if (!used && scan_phase == SCAN_DIGITS)
        begin
            d = char_digit(c);
            if (d != NO_DIGIT && d < digit_base)
            begin
                acc_value = acc_value * txtint_pkg::VALUE_W'(digit_base)
                          + txtint_pkg::VALUE_W'(d);
                bump_taken();
            end
            else
                scan_phase = SCAN_STOPPED;
        end
        if (last)
        begin
            res.value = minus_seen ? txtint_pkg::VALUE_W'(0) - acc_value : acc_value;
            res.count = taken_count[txtint_pkg::COUNT_W-1:0];
            pending_numbers.push_back(res);
            clear_scan();
        end
    endfunction

    function automatic int unsigned pick_pause(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sampling side: results, accepted bytes and register writes.
    always @(posedge clk)
    begin
        in_taken = s_axis_tvalid && s_axis_tready;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_numbers.size() == 0)
                    report_mismatch($sformatf("result %h with no string pending", m_axis_tdata));
                else
                begin
                    want = pending_numbers.pop_front();
                    strings_done++;
                    if (m_axis_tdata[txtint_pkg::VALUE_W-1:0] !== want.value)
                        report_mismatch($sformatf("value_bits %h, expected %h",
                                                  m_axis_tdata[txtint_pkg::VALUE_W-1:0],
                                                  want.value));
                    if (m_axis_tdata[txtint_pkg::OUT_DATA_W-1:txtint_pkg::VALUE_W] !== want.count)
                        report_mismatch($sformatf("consumed_count %0d, expected %0d",
                            m_axis_tdata[txtint_pkg::OUT_DATA_W-1:txtint_pkg::VALUE_W],
                            want.count));
                end
            end
            if (in_taken)
                scan_char(s_axis_tdata, s_axis_tlast);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == txtint_pkg::REG_RADIX)
                    radix_reg = cfg_data[txtint_pkg::RADIX_W-1:0];
                else if (cfg_index == txtint_pkg::REG_SIGNED_MODE)
                    signed_reg = cfg_data[0];
            end
        end
    end

    // Byte driver: holds a byte until its transaction completes, then waits out a gap.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (send_gap != 0)
            begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end
            else if (text_q.size() != 0)
            begin
                next_byte = text_q.pop_front();
                s_axis_tdata <= next_byte.ch;
                s_axis_tlast <= next_byte.last;
                s_axis_tvalid <= 1'b1;
                send_gap = pick_pause(calm_in);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (stall_left != 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                stall_left = pick_pause(calm_out);
            end
        end
    end

    task automatic write_reg(input logic [txtint_pkg::CFG_IDX_W-1:0] idx,
                             input logic [txtint_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(input int unsigned rdx, input bit sgn);
        write_reg(txtint_pkg::REG_RADIX, {2'($urandom), 6'(rdx)});
        write_reg(txtint_pkg::REG_SIGNED_MODE, {7'($urandom), sgn});
        settings_used++;
    endtask

    task automatic push_byte(input logic [txtint_pkg::CHAR_W-1:0] c, input logic last);
        text_byte_t b;
        b.ch = c;
        b.last = last;
        text_q.push_back(b);
        bytes_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], i == s.len() - 1);
    endtask

    task automatic wait_drained();
        int unsigned spent;
        spent = 0;
        do
        begin
            @(posedge clk);
            spent++;
        end while ((text_q.size() != 0 || s_axis_tvalid || pending_numbers.size() != 0)
                   && spent < 300000);
        if (pending_numbers.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", pending_numbers.size()));
            pending_numbers.delete();
        end
        // The last byte of a string may still be in flight inside the block.
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [txtint_pkg::CHAR_W-1:0] digit_char(input int unsigned v);
        if (v < 10)
            return txtint_pkg::CH_0 + txtint_pkg::CHAR_W'(v);
        return ($urandom_range(0, 1) ? txtint_pkg::CH_LA : txtint_pkg::CH_UA)
               + txtint_pkg::CHAR_W'(v - 10);
    endfunction

    function automatic logic [txtint_pkg::CHAR_W-1:0] pick_blank();
        logic [txtint_pkg::CHAR_W-1:0] blanks[6];
        blanks = '{txtint_pkg::CH_SPACE, txtint_pkg::CH_TAB, txtint_pkg::CH_LF,
                   txtint_pkg::CH_VT, txtint_pkg::CH_FF, txtint_pkg::CH_CR};
        return blanks[$urandom_range(0, 5)];
    endfunction

    // Mostly well-formed numbers in the current base, with some noise strings.
    task automatic push_random_string();
        logic [txtint_pkg::CHAR_W-1:0] txt[$];
        int unsigned                   n;
        int unsigned                   base;
        if ($urandom_range(0, 99) < 12)
        begin
            n = $urandom_range(1, 8);
            repeat (n) txt.push_back(txtint_pkg::CHAR_W'($urandom_range(0, 255)));
        end
        else
        begin
            n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(3, 12);
            repeat (n) txt.push_back(pick_blank());
            case ($urandom_range(0, 5))
                0: txt.push_back(txtint_pkg::CH_PLUS);
                1, 2: txt.push_back(txtint_pkg::CH_MINUS);
                default: ;
            endcase
            if (radix_reg == txtint_pkg::BASE_AUTO)
                base = 10;
            else if (radix_reg > 36)
                base = 36;
            else
                base = radix_reg;
            if (radix_reg == txtint_pkg::BASE_AUTO || radix_reg == txtint_pkg::BASE_16)
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        txt.push_back(txtint_pkg::CH_0);
                        txt.push_back($urandom_range(0, 1) ? txtint_pkg::CH_LX
                                                           : txtint_pkg::CH_UX);
                        base = 16;
                    end
                    1:
                    begin
                        txt.push_back(txtint_pkg::CH_0);
                        if (radix_reg == txtint_pkg::BASE_AUTO)
                            base = 8;
                    end
                    default: ;
                endcase
            end
            n = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 8) : $urandom_range(9, 30);
            repeat (n) txt.push_back(digit_char($urandom_range(0, base - 1)));
            if ($urandom_range(0, 1))
            begin
                case ($urandom_range(0, 3))
                    0: txt.push_back(8'h00);
                    1: txt.push_back(txtint_pkg::CH_MINUS);
                    2: txt.push_back(base < 36 ? digit_char($urandom_range(base, 35))
                                               : txtint_pkg::CH_SPACE);
                    default: txt.push_back(txtint_pkg::CHAR_W'($urandom_range(0, 255)));
                endcase
                n = $urandom_range(0, 3);
                repeat (n) txt.push_back(txtint_pkg::CHAR_W'($urandom_range(0, 255)));
            end
        end
        if (txt.size() == 0)
            txt.push_back(txtint_pkg::CHAR_W'($urandom_range(0, 255)));
        foreach (txt[i])
            push_byte(txt[i], i == txt.size() - 1);
    endtask

    task automatic random_phase(input int unsigned rdx, input bit sgn, input int unsigned nbytes);
        int unsigned stop_at;
        set_mode(rdx, sgn);
        calm_in = ($urandom_range(0, 3) == 0);
        calm_out = ($urandom_range(0, 3) == 0);
        stop_at = bytes_queued + nbytes;
        while (bytes_queued < stop_at)
            push_random_string();
        wait_drained();
    endtask

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        radix_reg = txtint_pkg::BASE_AUTO;
        signed_reg = 1'b1;
        clear_scan();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // Reset settings: auto-detected base, signed.
        settings_used++;
        push_byte(txtint_pkg::CH_TAB, 1'b0);
        push_byte(txtint_pkg::CH_LF, 1'b0);
        push_byte(txtint_pkg::CH_VT, 1'b0);
        push_byte(txtint_pkg::CH_FF, 1'b0);
        push_byte(txtint_pkg::CH_CR, 1'b0);
        push_text(" +12");
        push_text("-0xg");
        push_text("0");
        push_byte(8'hFF, 1'b1);
        push_byte(txtint_pkg::CH_MINUS, 1'b0);
        push_byte(8'h00, 1'b1);
        wait_drained();

        // Hexadecimal, unsigned: skipped prefix and a refused minus.
        set_mode(txtint_pkg::BASE_16, 1'b0);
        push_text("0xA");
        push_text("-5");
        wait_drained();

        write_reg(REG_SPARE, txtint_pkg::CFG_DATA_W'($urandom));
        set_mode(36, 1'b1);
        push_text("-zZ");
        wait_drained();

        random_phase(txtint_pkg::BASE_AUTO, 1'b1, 120);
        random_phase(txtint_pkg::BASE_AUTO, 1'b0, 120);
        random_phase(txtint_pkg::BASE_10, 1'b1, 110);
        random_phase(txtint_pkg::BASE_16, 1'b0, 120);
        random_phase(txtint_pkg::BASE_8, 1'b1, 110);
        random_phase(2, 1'b1, 110);
        random_phase(36, 1'b0, 110);
        random_phase(1, 1'b1, 80);
        random_phase(37, 1'b1, 100);
        random_phase(63, 1'b0, 100);
        for (int i = 0; i < 5; i++)
            random_phase($urandom_range(0, 63), $urandom_range(0, 1), 110);

        // A long run of blanks ahead of a single digit.
        set_mode(txtint_pkg::BASE_10, 1'b1);
        calm_in = 1'b1;
        repeat (LONG_BLANK_RUN) push_byte(txtint_pkg::CH_SPACE, 1'b0);
        push_byte(txtint_pkg::CH_0 + 8'd7, 1'b1);
        wait_drained();

        $display("Parsed %0d strings from %0d bytes under %0d radix/sign settings,",
                 strings_done, bytes_queued, settings_used);
        $display("including one blank run of %0d bytes; %0d mismatches.",
                 LONG_BLANK_RUN, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: text_to_integer_radix_parser.f
rtl/txtint_pkg.sv
rtl/text_to_integer_radix_parser.sv
rtl/txtint_checker.sv
bench/text_to_integer_radix_parser_test.sv
